### rtl/ssort_pkg.sv
// Shared constants for the Shell sort block with the halving gap sequence.
// No dependencies; the top level imports it.
`default_nettype none

package ssort_pkg;

    // Default capacity of the element store
    localparam int DEFAULT_MAX_ITEMS  = 64;
    // Default stored value width in bits
    localparam int DEFAULT_DATA_WIDTH = 32;
    // Width of the value fields on both channels
    localparam int ITEM_WIDTH         = 32;

endpackage : ssort_pkg

`default_nettype wire

### rtl/shell_sort_halving_gaps.sv
// Top level of the Shell sort block: element store, sort sequencer and output register.
// Depends on ssort_pkg for the default parameter values and the field width.
`default_nettype none

// Values arrive one per transfer on the s_ channel and go into a store of MAX_ITEMS
// entries. The store takes one item per cycle while loading. An item marked last closes
// the set. The block then sorts the store in place with gaps n/2, n/4, ..., 1, and emits
// the n values in ascending signed order on the m_ channel with the final one marked.
// While sorting and emitting, s_ready is low. One memory port pair (one write, one
// registered read per cycle) sets the rate. Each element at each gap is read, its
// gapped neighbor is fetched and compared, and each larger neighbor moves up one gap
// until the element is placed. Each result is read, loaded into the output register
// and held until m_ready. Items that arrive while the store is full are dropped, and
// m_overflow is then high on every result of that set. Only the low DATA_WIDTH bits of
// s_item_value are kept, up to 32, read as two's complement and sign-extended on output.
module shell_sort_halving_gaps
    import ssort_pkg::*;
#(
    parameter int MAX_ITEMS  = DEFAULT_MAX_ITEMS,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire signed [ITEM_WIDTH-1:0]  s_item_value,
    input  wire                          s_last_item,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [ITEM_WIDTH-1:0] m_sorted_value,
    output logic                         m_last_result,
    output logic                         m_overflow
);

    localparam int VW = (DATA_WIDTH < ITEM_WIDTH) ? DATA_WIDTH : ITEM_WIDTH;
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_RD_J,
        S_CMP,
        S_PUT,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [CW-1:0]        gap_reg, gap_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic signed [VW-1:0] temp_reg, temp_next;
    logic signed [VW-1:0] rdata_reg;

    logic signed [ITEM_WIDTH-1:0] m_value_reg, m_value_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_ovf_reg, m_ovf_next;
    logic                         m_valid_reg, m_valid_next;

    // Element store
    logic [VW-1:0] mem [MAX_ITEMS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    // Address arithmetic
    logic          full;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] load_n;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_back;
    logic [CW-1:0] pos_back;
    logic [CW-1:0] pos_back2;
    logic [CW-1:0] gap_half;

    assign full      = (count_reg == CW'(MAX_ITEMS));
    assign count_inc = count_reg + 1'b1;
    assign load_n    = full ? count_reg : count_inc;
    assign idx_inc   = idx_reg + 1'b1;
    assign idx_back  = idx_reg - gap_reg;
    assign pos_back  = pos_reg - gap_reg;
    assign pos_back2 = pos_back - gap_reg;
    assign gap_half  = gap_reg >> 1;

    assign s_ready        = (state_reg == S_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_last_result  = m_last_reg;
    assign m_overflow     = m_ovf_reg;

    // Write one entry and read one entry per cycle, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Sequencer: load, gapped insertion passes, emit
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        gap_next     = gap_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        temp_next    = temp_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg[IW-1:0];
        mem_wdata    = temp_reg;
        mem_raddr    = idx_reg[IW-1:0];

        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    // Store the item, or drop it and flag overflow
                    if (!full) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IW-1:0];
                        mem_wdata  = s_item_value[VW-1:0];
                        count_next = count_inc;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last_item) begin
                        gap_next = load_n >> 1;
                        if ((load_n >> 1) == '0) begin
                            idx_next   = '0;
                            state_next = S_OUT_RD;
                        end else begin
                            idx_next   = load_n >> 1;
                            state_next = S_RD_I;
                        end
                    end
                end
            end

            S_RD_I: begin
                mem_raddr  = idx_reg[IW-1:0];
                state_next = S_RD_J;
            end

            S_RD_J: begin
                // Hold the element being inserted, fetch its gapped neighbor
                temp_next  = rdata_reg;
                pos_next   = idx_reg;
                mem_raddr  = idx_back[IW-1:0];
                state_next = S_CMP;
            end

            S_CMP: begin
                if (temp_reg < rdata_reg) begin
                    // Shift the larger neighbor up by one gap
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[IW-1:0];
                    mem_wdata = rdata_reg;
                    pos_next  = pos_back;
                    if (pos_back >= gap_reg) begin
                        mem_raddr = pos_back2[IW-1:0];
                    end else begin
                        state_next = S_PUT;
                    end
                end else begin
                    // Drop the held element into its slot and advance
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[IW-1:0];
                    mem_wdata = temp_reg;
                    if (idx_inc < count_reg) begin
                        idx_next   = idx_inc;
                        state_next = S_RD_I;
                    end else begin
                        gap_next = gap_half;
                        if (gap_half == '0) begin
                            idx_next   = '0;
                            state_next = S_OUT_RD;
                        end else begin
                            idx_next   = gap_half;
                            state_next = S_RD_I;
                        end
                    end
                end
            end

            S_PUT: begin
                // Place the held element at the bottom of its chain and advance
                mem_we    = 1'b1;
                mem_waddr = pos_reg[IW-1:0];
                mem_wdata = temp_reg;
                if (idx_inc < count_reg) begin
                    idx_next   = idx_inc;
                    state_next = S_RD_I;
                end else begin
                    gap_next = gap_half;
                    if (gap_half == '0) begin
                        idx_next   = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        idx_next   = gap_half;
                        state_next = S_RD_I;
                    end
                end
            end

            S_OUT_RD: begin
                mem_raddr  = idx_reg[IW-1:0];
                state_next = S_OUT_LD;
            end

            S_OUT_LD: begin
                // Load the output register, sign-extended
                m_value_next = ITEM_WIDTH'(rdata_reg);
                m_last_next  = (idx_inc == count_reg);
                m_ovf_next   = ovf_reg;
                m_valid_next = 1'b1;
                state_next   = S_OUT_WAIT;
            end

            S_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        // Set done: start a new one
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        gap_reg     <= gap_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        temp_reg    <= temp_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
    end

endmodule : shell_sort_halving_gaps

`default_nettype wire
